// File: sv/ahm_pkg.sv
// shared constants, types and codes for the assignment matcher
// used by the sequencer, the column cells, the top level and the checker
// no dependencies

package ahm_pkg;

  localparam int MAX_SIZE  = 16;
  localparam int IDX_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int COST_W    = 16;
  localparam int WCOST_W   = 17;
  localparam int LABEL_W   = 24;
  localparam int SLACK_W   = 25;
  localparam int TOTAL_W   = 20;
  localparam int SUM_W     = 21;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DW    = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MINIMIZE = CFG_IDX_W'(1);

  // operations broadcast to the column cells
  typedef enum logic [3:0] {
    OP_NOP,
    OP_SHIFT,
    OP_CLEAR,
    OP_TREE_CLR,
    OP_TIGHT,
    OP_SLACK_INIT,
    OP_SLACK_MIN,
    OP_RELABEL,
    OP_SET_TREE,
    OP_SET_PARTNER
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic [IDX_W-1:0]           sel_col;
    logic [IDX_W-1:0]           row;
    logic signed [LABEL_W-1:0]  rl;
    logic signed [SLACK_W-1:0]  delta;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [SLACK_W-1:0]  slack;
    logic [IDX_W-1:0]           src;
    logic                       pv;
    logic [IDX_W-1:0]           partner;
    logic                       in_tree;
    logic                       tight;
    logic                       zero;
  } cell_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_RLOAD,
    S_RDONE,
    S_START,
    S_BFS,
    S_TSCAN,
    S_DMIN,
    S_RELAB,
    S_ZSCAN,
    S_AUG,
    S_ORD,
    S_OWAIT,
    S_OHOLD
  } seq_state_t;

  // purpose of a row load into the cell chain
  typedef enum logic [1:0] {
    LK_MAX,
    LK_ROOT,
    LK_TIGHT,
    LK_ADD
  } load_kind_t;

endpackage

// File: sv/ahm_col_cell.sv
// one column cell of the matcher chain: label, slack, partner and tree flags
// shifts row costs to its neighbor; depends on ahm_pkg

module ahm_col_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ahm_pkg::cell_cmd_t                  cmd,
  input  logic                                sel,
  input  logic signed [ahm_pkg::WCOST_W-1:0]  cost_in,
  output logic signed [ahm_pkg::WCOST_W-1:0]  cost_out,
  output ahm_pkg::cell_stat_t                 stat
);

  logic signed [ahm_pkg::WCOST_W-1:0] cost_r;
  logic signed [ahm_pkg::LABEL_W-1:0] label_r;
  logic signed [ahm_pkg::SLACK_W-1:0] slack_r;
  logic [ahm_pkg::IDX_W-1:0]          src_r;
  logic                               pv_r;
  logic [ahm_pkg::IDX_W-1:0]          partner_r;
  logic                               in_tree_r;
  logic                               tight_r;

  logic signed [ahm_pkg::SLACK_W:0]   lsum;
  logic signed [ahm_pkg::SLACK_W:0]   s_full;
  logic signed [ahm_pkg::SLACK_W-1:0] s_val;

  // row label plus column label, and slack against the held cost
  assign lsum   = (ahm_pkg::SLACK_W+1)'(cmd.rl) + (ahm_pkg::SLACK_W+1)'(label_r);
  assign s_full = lsum - (ahm_pkg::SLACK_W+1)'(cost_r);
  assign s_val  = s_full[ahm_pkg::SLACK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r   <= '0;
      pv_r      <= 1'b0;
      in_tree_r <= 1'b0;
      tight_r   <= 1'b0;
    end else begin
      case (cmd.op)
        ahm_pkg::OP_SHIFT: begin
          cost_r <= cost_in;
        end
        ahm_pkg::OP_CLEAR: begin
          label_r <= '0;
          pv_r    <= 1'b0;
        end
        ahm_pkg::OP_TREE_CLR: begin
          in_tree_r <= 1'b0;
          tight_r   <= 1'b0;
        end
        ahm_pkg::OP_TIGHT: begin
          tight_r <= !in_tree_r && (lsum == (ahm_pkg::SLACK_W+1)'(cost_r));
        end
        ahm_pkg::OP_SLACK_INIT: begin
          slack_r <= s_val;
          src_r   <= cmd.row;
        end
        ahm_pkg::OP_SLACK_MIN: begin
          if (s_val < slack_r) begin
            slack_r <= s_val;
            src_r   <= cmd.row;
          end
        end
        ahm_pkg::OP_RELABEL: begin
          if (in_tree_r) label_r <= label_r + cmd.delta[ahm_pkg::LABEL_W-1:0];
          else           slack_r <= slack_r - cmd.delta;
        end
        ahm_pkg::OP_SET_TREE: begin
          if (sel) begin
            in_tree_r <= 1'b1;
            tight_r   <= 1'b0;
          end
        end
        ahm_pkg::OP_SET_PARTNER: begin
          if (sel) begin
            pv_r      <= 1'b1;
            partner_r <= cmd.row;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // status toward the sequencer
  assign cost_out     = cost_r;
  assign stat.slack   = slack_r;
  assign stat.src     = src_r;
  assign stat.pv      = pv_r;
  assign stat.partner = partner_r;
  assign stat.in_tree = in_tree_r;
  assign stat.tight   = tight_r;
  assign stat.zero    = (slack_r == '0);

endmodule

// File: sv/ahm_seq.sv
// sequencer of the matcher: cost memory, row state, search queue, handshakes
// drives the column cell chain; depends on ahm_pkg

module ahm_seq (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ahm_pkg::COST_W-1:0]     in_cost_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ahm_pkg::IDX_W-1:0]             out_row_index,
  output logic [ahm_pkg::IDX_W-1:0]             out_matched_column,
  output logic signed [ahm_pkg::COST_W-1:0]     out_row_cost,
  output logic [ahm_pkg::TOTAL_W-1:0]           out_total_weight,
  output logic                                  out_last_result,
  input  logic                                  cfg_we,
  input  logic [ahm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ahm_pkg::CFG_DW-1:0]            cfg_wdata,
  output ahm_pkg::cell_cmd_t                    cmd,
  output logic signed [ahm_pkg::WCOST_W-1:0]    feed,
  input  ahm_pkg::cell_stat_t [ahm_pkg::MAX_SIZE-1:0] stat
);

  localparam int IW = ahm_pkg::IDX_W;
  localparam int NW = ahm_pkg::SIZE_W;
  localparam int MS = ahm_pkg::MAX_SIZE;

  // lowest set bit of a mask, with a found flag on top
  function automatic logic [IW:0] lowest(input logic [MS-1:0] m);
    logic [IW:0] res;
    res = '0;
    for (int i = MS - 1; i >= 0; i--) begin
      if (m[i]) res = {1'b1, IW'(i)};
    end
    return res;
  endfunction

  ahm_pkg::seq_state_t state_r, state_nxt;
  ahm_pkg::load_kind_t ld_kind_r;

  logic [NW-1:0] size_r;
  logic          minimize_r;
  logic [IW-1:0] ld_row_r, ld_col_r;

  // cost memory
  logic signed [ahm_pkg::WCOST_W-1:0] mem [2**ahm_pkg::ADDR_W];
  logic signed [ahm_pkg::WCOST_W-1:0] mem_q_r;
  logic [ahm_pkg::ADDR_W-1:0]         rd_addr;
  logic signed [ahm_pkg::WCOST_W-1:0] wr_data;

  // row state
  logic signed [ahm_pkg::LABEL_W-1:0] row_label_r [MS];
  logic [MS-1:0]                      row_pv_r;
  logic [IW-1:0]                      row_p_r [MS];
  logic [MS-1:0]                      row_in_tree_r;
  logic [MS-1:0]                      tree_pv_r;
  logic [IW-1:0]                      tree_par_r [MS];
  logic [IW-1:0]                      queue_r [MS];
  logic [NW-1:0]                      wr_r, rd_r;
  logic [NW-1:0]                      match_cnt_r;

  // row load and scan control
  logic [NW-1:0]                      k_r;
  logic                               rdv_r;
  logic [IW-1:0]                      ld_x_r, scan_x_r;
  logic                               ret_z_r;
  logic signed [ahm_pkg::LABEL_W-1:0] max_r;
  logic [NW-1:0]                      cursor_r;
  logic [NW-1:0]                      dy_r;
  logic signed [ahm_pkg::SLACK_W-1:0] d_r;
  logic                               dv_r;

  // augmenting walk
  logic [IW-1:0] fx_r, fy_r;
  logic          fx_v_r, fy_v_r;
  logic [NW-1:0] steps_r;

  // output side
  logic [IW-1:0]                       r_r, c_r;
  logic signed [ahm_pkg::SUM_W-1:0]    total_r;
  logic                                out_valid_r;
  logic [IW-1:0]                       out_row_r, out_col_r;
  logic signed [ahm_pkg::COST_W-1:0]   out_cost_r;
  logic [ahm_pkg::TOTAL_W-1:0]         out_total_r;
  logic                                out_last_r;

  logic [NW-1:0] n_eff, n_m1;
  logic [MS-1:0] tight_mask, zero_mask, unm_mask;
  logic [IW:0]   tight_lo, zero_lo, root_lo;
  logic [IW-1:0] y_rd, c_sel, ty, zy, tp, zp, root;
  logic          in_acc, ld_last, aug_go;
  logic signed [ahm_pkg::SUM_W-1:0]     total_nxt, total_abs;
  logic signed [ahm_pkg::WCOST_W-1:0]   w_neg;

  // effective matrix size
  always_comb begin
    if (size_r == '0)                 n_eff = NW'(1);
    else if (size_r > NW'(MS))        n_eff = NW'(MS);
    else                              n_eff = size_r;
  end
  assign n_m1 = n_eff - NW'(1);

  // column masks from the cells
  always_comb begin
    for (int i = 0; i < MS; i++) begin
      tight_mask[i] = stat[i].tight && (NW'(i) < n_eff);
      zero_mask[i]  = stat[i].zero && !stat[i].in_tree && (NW'(i) < n_eff)
                      && (NW'(i) >= cursor_r);
      unm_mask[i]   = !row_pv_r[i] && (NW'(i) < n_eff);
    end
  end

  assign tight_lo = lowest(tight_mask);
  assign zero_lo  = lowest(zero_mask);
  assign root_lo  = lowest(unm_mask);
  assign ty       = tight_lo[IW-1:0];
  assign zy       = zero_lo[IW-1:0];
  assign tp       = stat[ty].partner;
  assign zp       = stat[zy].partner;
  assign root     = root_lo[IW] ? root_lo[IW-1:0] : '0;

  assign in_acc  = in_valid && in_ready;
  assign ld_last = ({1'b0, ld_row_r} == n_m1) && ({1'b0, ld_col_r} == n_m1);
  assign y_rd    = IW'(n_m1 - k_r);
  assign c_sel   = (row_pv_r[r_r] && ({1'b0, row_p_r[r_r]} < n_eff)) ? row_p_r[r_r] : '0;
  assign aug_go  = fx_v_r && fy_v_r && ({1'b0, fx_r} < n_eff) && ({1'b0, fy_r} < n_eff)
                   && (steps_r <= n_eff);
  assign wr_data = minimize_r ? -ahm_pkg::WCOST_W'(in_cost_value)
                              : ahm_pkg::WCOST_W'(in_cost_value);
  assign total_nxt = total_r + ahm_pkg::SUM_W'(mem_q_r);
  assign total_abs = total_nxt[ahm_pkg::SUM_W-1] ? -total_nxt : total_nxt;
  assign w_neg     = -mem_q_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ahm_pkg::S_LOAD:  if (in_acc && ld_last && !cfg_we) state_nxt = ahm_pkg::S_INIT;
      ahm_pkg::S_INIT:  state_nxt = ahm_pkg::S_RLOAD;
      ahm_pkg::S_RLOAD: if (k_r == n_eff) state_nxt = ahm_pkg::S_RDONE;
      ahm_pkg::S_RDONE: begin
        case (ld_kind_r)
          ahm_pkg::LK_MAX:   state_nxt = ({1'b0, ld_x_r} == n_m1) ? ahm_pkg::S_START
                                                                  : ahm_pkg::S_RLOAD;
          ahm_pkg::LK_ROOT:  state_nxt = ahm_pkg::S_BFS;
          ahm_pkg::LK_TIGHT: state_nxt = ahm_pkg::S_TSCAN;
          default:           state_nxt = ret_z_r ? ahm_pkg::S_ZSCAN : ahm_pkg::S_TSCAN;
        endcase
      end
      ahm_pkg::S_START: state_nxt = (match_cnt_r == n_eff) ? ahm_pkg::S_ORD
                                                           : ahm_pkg::S_RLOAD;
      ahm_pkg::S_BFS:   state_nxt = (rd_r < wr_r) ? ahm_pkg::S_RLOAD : ahm_pkg::S_DMIN;
      ahm_pkg::S_TSCAN: begin
        if (!tight_lo[IW])          state_nxt = ahm_pkg::S_BFS;
        else if (!stat[ty].pv)      state_nxt = ahm_pkg::S_AUG;
        else                        state_nxt = ahm_pkg::S_RLOAD;
      end
      ahm_pkg::S_DMIN:  if (dy_r >= n_eff) state_nxt = ahm_pkg::S_RELAB;
      ahm_pkg::S_RELAB: state_nxt = ahm_pkg::S_ZSCAN;
      ahm_pkg::S_ZSCAN: begin
        if (!zero_lo[IW])           state_nxt = ahm_pkg::S_BFS;
        else if (!stat[zy].pv)      state_nxt = ahm_pkg::S_AUG;
        else if (!row_in_tree_r[zp]) state_nxt = ahm_pkg::S_RLOAD;
      end
      ahm_pkg::S_AUG:   if (!aug_go) state_nxt = ahm_pkg::S_START;
      ahm_pkg::S_ORD:   state_nxt = ahm_pkg::S_OWAIT;
      ahm_pkg::S_OWAIT: state_nxt = ahm_pkg::S_OHOLD;
      ahm_pkg::S_OHOLD: begin
        if (out_ready) state_nxt = out_last_r ? ahm_pkg::S_LOAD : ahm_pkg::S_ORD;
      end
      default:          state_nxt = ahm_pkg::S_LOAD;
    endcase
  end

  // cell commands, memory read address and handshake outputs
  always_comb begin
    cmd         = '0;
    cmd.op      = ahm_pkg::OP_NOP;
    cmd.row     = ld_x_r;
    cmd.rl      = row_label_r[ld_x_r];
    cmd.delta   = dv_r ? d_r : '0;
    rd_addr     = {ld_x_r, y_rd};
    in_ready    = (state_r == ahm_pkg::S_LOAD);
    case (state_r)
      ahm_pkg::S_INIT:  cmd.op = ahm_pkg::OP_CLEAR;
      ahm_pkg::S_RLOAD: if (rdv_r) cmd.op = ahm_pkg::OP_SHIFT;
      ahm_pkg::S_RDONE: begin
        case (ld_kind_r)
          ahm_pkg::LK_ROOT:  cmd.op = ahm_pkg::OP_SLACK_INIT;
          ahm_pkg::LK_TIGHT: cmd.op = ahm_pkg::OP_TIGHT;
          ahm_pkg::LK_ADD:   cmd.op = ahm_pkg::OP_SLACK_MIN;
          default:           cmd.op = ahm_pkg::OP_NOP;
        endcase
      end
      ahm_pkg::S_START: if (match_cnt_r != n_eff) cmd.op = ahm_pkg::OP_TREE_CLR;
      ahm_pkg::S_RELAB: cmd.op = ahm_pkg::OP_RELABEL;
      ahm_pkg::S_TSCAN: begin
        if (tight_lo[IW] && stat[ty].pv) begin
          cmd.op      = ahm_pkg::OP_SET_TREE;
          cmd.sel_col = ty;
        end
      end
      ahm_pkg::S_ZSCAN: begin
        if (zero_lo[IW] && stat[zy].pv) begin
          cmd.op      = ahm_pkg::OP_SET_TREE;
          cmd.sel_col = zy;
        end
      end
      ahm_pkg::S_AUG: begin
        if (aug_go) begin
          cmd.op      = ahm_pkg::OP_SET_PARTNER;
          cmd.sel_col = fy_r;
          cmd.row     = fx_r;
        end
      end
      ahm_pkg::S_ORD: rd_addr = {r_r, c_sel};
      default: begin
      end
    endcase
  end

  assign feed = mem_q_r;

  // cost memory, registered read
  always_ff @(posedge clk) begin
    if (in_acc) mem[{ld_row_r, ld_col_r}] <= wr_data;
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ahm_pkg::S_LOAD;
    else        state_r <= state_nxt;
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r        <= NW'(MS);
      minimize_r    <= 1'b1;
      ld_row_r      <= '0;
      ld_col_r      <= '0;
      row_pv_r      <= '0;
      row_in_tree_r <= '0;
      tree_pv_r     <= '0;
      match_cnt_r   <= '0;
      k_r           <= '0;
      rdv_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      case (state_r)
        ahm_pkg::S_LOAD: begin
          if (in_acc && !cfg_we) begin
            if (ld_last) begin
              ld_row_r <= '0;
              ld_col_r <= '0;
            end else if ({1'b0, ld_col_r} == n_m1) begin
              ld_col_r <= '0;
              ld_row_r <= ld_row_r + IW'(1);
            end else begin
              ld_col_r <= ld_col_r + IW'(1);
            end
          end
        end
        ahm_pkg::S_INIT: begin
          row_pv_r    <= '0;
          match_cnt_r <= '0;
          ld_x_r      <= '0;
          ld_kind_r   <= ahm_pkg::LK_MAX;
          k_r         <= '0;
          rdv_r       <= 1'b0;
          max_r       <= '0;
        end
        ahm_pkg::S_RLOAD: begin
          k_r   <= k_r + NW'(1);
          rdv_r <= (k_r < n_eff);
          if (rdv_r && (ahm_pkg::LABEL_W'(mem_q_r) > max_r)) max_r <= ahm_pkg::LABEL_W'(mem_q_r);
        end
        ahm_pkg::S_RDONE: begin
          k_r   <= '0;
          rdv_r <= 1'b0;
          if (ld_kind_r == ahm_pkg::LK_MAX) begin
            row_label_r[ld_x_r] <= max_r;
            ld_x_r              <= ld_x_r + IW'(1);
            max_r               <= '0;
          end
        end
        ahm_pkg::S_START: begin
          if (match_cnt_r == n_eff) begin
            r_r     <= '0;
            total_r <= '0;
          end else begin
            row_in_tree_r       <= MS'(1) << root;
            tree_pv_r           <= '0;
            queue_r[0]          <= root;
            wr_r                <= NW'(1);
            rd_r                <= '0;
            ld_x_r              <= root;
            ld_kind_r           <= ahm_pkg::LK_ROOT;
            k_r                 <= '0;
            rdv_r               <= 1'b0;
          end
        end
        ahm_pkg::S_BFS: begin
          if (rd_r < wr_r) begin
            scan_x_r  <= queue_r[rd_r[IW-1:0]];
            ld_x_r    <= queue_r[rd_r[IW-1:0]];
            rd_r      <= rd_r + NW'(1);
            ld_kind_r <= ahm_pkg::LK_TIGHT;
            k_r       <= '0;
            rdv_r     <= 1'b0;
          end else begin
            dy_r <= '0;
            dv_r <= 1'b0;
          end
        end
        ahm_pkg::S_TSCAN: begin
          if (tight_lo[IW]) begin
            if (!stat[ty].pv) begin
              fx_r        <= scan_x_r;
              fx_v_r      <= 1'b1;
              fy_r        <= ty;
              fy_v_r      <= 1'b1;
              steps_r     <= '0;
              match_cnt_r <= match_cnt_r + NW'(1);
            end else begin
              if (wr_r < NW'(MS)) begin
                queue_r[wr_r[IW-1:0]] <= tp;
                wr_r                  <= wr_r + NW'(1);
              end
              tree_pv_r[tp]     <= 1'b1;
              tree_par_r[tp]    <= scan_x_r;
              row_in_tree_r[tp] <= 1'b1;
              ld_x_r            <= tp;
              ld_kind_r         <= ahm_pkg::LK_ADD;
              ret_z_r           <= 1'b0;
              k_r               <= '0;
              rdv_r             <= 1'b0;
            end
          end
        end
        ahm_pkg::S_DMIN: begin
          if (dy_r < n_eff) begin
            if (!stat[dy_r[IW-1:0]].in_tree && (!dv_r || (stat[dy_r[IW-1:0]].slack < d_r))) begin
              d_r  <= stat[dy_r[IW-1:0]].slack;
              dv_r <= 1'b1;
            end
            dy_r <= dy_r + NW'(1);
          end
        end
        ahm_pkg::S_RELAB: begin
          for (int i = 0; i < MS; i++) begin
            if (row_in_tree_r[i]) row_label_r[i] <= row_label_r[i] - cmd.delta[ahm_pkg::LABEL_W-1:0];
          end
          wr_r     <= '0;
          rd_r     <= '0;
          cursor_r <= '0;
        end
        ahm_pkg::S_ZSCAN: begin
          if (zero_lo[IW]) begin
            if (!stat[zy].pv) begin
              fx_r        <= stat[zy].src;
              fx_v_r      <= 1'b1;
              fy_r        <= zy;
              fy_v_r      <= 1'b1;
              steps_r     <= '0;
              match_cnt_r <= match_cnt_r + NW'(1);
            end else begin
              cursor_r <= {1'b0, zy} + NW'(1);
              if (!row_in_tree_r[zp]) begin
                if (wr_r < NW'(MS)) begin
                  queue_r[wr_r[IW-1:0]] <= zp;
                  wr_r                  <= wr_r + NW'(1);
                end
                tree_pv_r[zp]     <= 1'b1;
                tree_par_r[zp]    <= stat[zy].src;
                row_in_tree_r[zp] <= 1'b1;
                ld_x_r            <= zp;
                ld_kind_r         <= ahm_pkg::LK_ADD;
                ret_z_r           <= 1'b1;
                k_r               <= '0;
                rdv_r             <= 1'b0;
              end
            end
          end
        end
        ahm_pkg::S_AUG: begin
          if (aug_go) begin
            row_pv_r[fx_r] <= 1'b1;
            row_p_r[fx_r]  <= fy_r;
            fx_r           <= tree_par_r[fx_r];
            fx_v_r         <= tree_pv_r[fx_r];
            fy_r           <= row_p_r[fx_r];
            fy_v_r         <= row_pv_r[fx_r];
            steps_r        <= steps_r + NW'(1);
          end
        end
        ahm_pkg::S_ORD: begin
          c_r <= c_sel;
        end
        ahm_pkg::S_OWAIT: begin
          total_r     <= total_nxt;
          out_valid_r <= 1'b1;
          out_row_r   <= r_r;
          out_col_r   <= c_r;
          out_cost_r  <= minimize_r ? w_neg[ahm_pkg::COST_W-1:0] : mem_q_r[ahm_pkg::COST_W-1:0];
          out_last_r  <= ({1'b0, r_r} == n_m1);
          out_total_r <= ({1'b0, r_r} == n_m1) ? total_abs[ahm_pkg::TOTAL_W-1:0] : '0;
        end
        ahm_pkg::S_OHOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            r_r         <= r_r + IW'(1);
          end
        end
        default: begin
        end
      endcase
      // configuration writes restart loading
      if (cfg_we) begin
        ld_row_r <= '0;
        ld_col_r <= '0;
        if (cfg_index == ahm_pkg::CFG_SIZE)     size_r     <= cfg_wdata;
        if (cfg_index == ahm_pkg::CFG_MINIMIZE) minimize_r <= cfg_wdata[0];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_index      = out_row_r;
  assign out_matched_column = out_col_r;
  assign out_row_cost       = out_cost_r;
  assign out_total_weight   = out_total_r;
  assign out_last_result    = out_last_r;

endmodule

// File: sv/assignment_hungarian_matcher_core.sv
// assignment matcher top: n*n costs load at one item per cycle, then n augmentations
// each augmentation loads every tree row twice, for slacks and for the tight scan,
// and relabels in states S_DMIN and S_RELAB; rows stream through 16 column cells
// results: n items, row 0 first, each held in S_OHOLD until out_ready takes it
// reset is synchronous and active low: size 16, minimize on, loading from entry 0
// depends on ahm_pkg, ahm_seq and ahm_col_cell

module assignment_hungarian_matcher_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ahm_pkg::COST_W-1:0]   in_cost_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ahm_pkg::IDX_W-1:0]           out_row_index,
  output logic [ahm_pkg::IDX_W-1:0]           out_matched_column,
  output logic signed [ahm_pkg::COST_W-1:0]   out_row_cost,
  output logic [ahm_pkg::TOTAL_W-1:0]         out_total_weight,
  output logic                                out_last_result,
  input  logic                                cfg_we,
  input  logic [ahm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ahm_pkg::CFG_DW-1:0]          cfg_wdata
);

  ahm_pkg::cell_cmd_t                          cmd;
  ahm_pkg::cell_stat_t [ahm_pkg::MAX_SIZE-1:0] stat;
  logic signed [ahm_pkg::WCOST_W-1:0]          chain [ahm_pkg::MAX_SIZE+1];

  // sequencer
  ahm_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cost_value      (in_cost_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_index      (out_row_index),
    .out_matched_column (out_matched_column),
    .out_row_cost       (out_row_cost),
    .out_total_weight   (out_total_weight),
    .out_last_result    (out_last_result),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .feed               (chain[0]),
    .stat               (stat)
  );

  // column cell chain, costs shift from cell 0 upward
  for (genvar i = 0; i < ahm_pkg::MAX_SIZE; i++) begin : g_cell
    ahm_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (cmd.sel_col == ahm_pkg::IDX_W'(i)),
      .cost_in  (chain[i]),
      .cost_out (chain[i+1]),
      .stat     (stat[i])
    );
  end

endmodule

// File: sv/ahm_checker.sv
// port-level checker for the assignment matcher, bound to the top level
// depends on ahm_pkg and assignment_hungarian_matcher_core

module ahm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ahm_pkg::IDX_W-1:0]           out_row_index,
  input logic [ahm_pkg::IDX_W-1:0]           out_matched_column,
  input logic signed [ahm_pkg::COST_W-1:0]   out_row_cost,
  input logic [ahm_pkg::TOTAL_W-1:0]         out_total_weight,
  input logic                                out_last_result
);

  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result item is pending");

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index)
      && $stable(out_matched_column) && $stable(out_row_cost)
      && $stable(out_last_result))
    else $error("result item changed while stalled");

  // total is reported only with the final item
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> out_total_weight == '0)
    else $error("total weight on a non-final item");

  // more results follow a non-final item before loading resumes
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=> !in_ready)
    else $error("loading resumed before the final item");

  // loading resumes right after the final item
  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready)
    else $error("loading did not resume after the final item");

endmodule

bind assignment_hungarian_matcher_core ahm_checker u_ahm_checker (.*);

// File: verif/tb_assignment_hungarian_matcher_core.sv
// testbench for the assignment matcher: square cost matrices in, one match per row out
// holds its own O(n^3) label/slack solver and checks every row item field by field
// depends on ahm_pkg and assignment_hungarian_matcher_core
`timescale 1ns / 1ps

module tb_assignment_hungarian_matcher_core;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int NO_MATE        = -1;
  localparam int ROOT_MARK      = -2;
  localparam int RAND_BUDGET    = 55;
  localparam logic [ahm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = ahm_pkg::CFG_IDX_W'(7);

  // one row assignment as the block reports it
  typedef struct {
    logic [ahm_pkg::IDX_W-1:0]         row;
    logic [ahm_pkg::IDX_W-1:0]         col;
    logic signed [ahm_pkg::COST_W-1:0] cost;
    logic [ahm_pkg::TOTAL_W-1:0]       total;
    logic                              last;
  } row_match_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [ahm_pkg::COST_W-1:0]   in_cost_value;
  logic                                out_valid;
  logic                                out_ready;
  logic [ahm_pkg::IDX_W-1:0]           out_row_index;
  logic [ahm_pkg::IDX_W-1:0]           out_matched_column;
  logic signed [ahm_pkg::COST_W-1:0]   out_row_cost;
  logic [ahm_pkg::TOTAL_W-1:0]         out_total_weight;
  logic                                out_last_result;
  logic                                cfg_we;
  logic [ahm_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [ahm_pkg::CFG_DW-1:0]          cfg_wdata;

  logic signed [ahm_pkg::COST_W-1:0]   cost_feed_q[$];
  row_match_t                          match_q[$];
  int                                  send_idle_pct;
  int                                  recv_idle_pct;
  int                                  fail_count;
  int                                  stall_cycles;

  // solver state
  longint     mat[ahm_pkg::MAX_SIZE*ahm_pkg::MAX_SIZE];
  longint     rlab[ahm_pkg::MAX_SIZE];
  longint     clab[ahm_pkg::MAX_SIZE];
  int         rmate[ahm_pkg::MAX_SIZE];
  int         cmate[ahm_pkg::MAX_SIZE];
  bit         rtree[ahm_pkg::MAX_SIZE];
  bit         ctree[ahm_pkg::MAX_SIZE];
  longint     slack[ahm_pkg::MAX_SIZE];
  int         slack_row[ahm_pkg::MAX_SIZE];
  int         parent[ahm_pkg::MAX_SIZE];
  int         bfs_q[ahm_pkg::MAX_SIZE];
  int         fill_count;
  logic [4:0] size_reg;
  bit         minimize_reg;

  assignment_hungarian_matcher_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cost_value      (in_cost_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_row_index      (out_row_index),
    .out_matched_column (out_matched_column),
    .out_row_cost       (out_row_cost),
    .out_total_weight   (out_total_weight),
    .out_last_result    (out_last_result),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > ahm_pkg::MAX_SIZE) return ahm_pkg::MAX_SIZE;
    return int'(size_reg);
  endfunction

  // add row x to the alternating tree and tighten column slacks
  function automatic void grow_tree(int n, int x, int par);
    longint s;
    rtree[x] = 1'b1;
    parent[x] = par;
    for (int y = 0; y < n; y++) begin
      s = rlab[x] + clab[y] - mat[x*n+y];
      if (s < slack[y]) begin
        slack[y] = s;
        slack_row[y] = x;
      end
    end
  endfunction

  function automatic void shift_labels(int n);
    longint delta;
    bit     seen;
    seen = 1'b0;
    delta = 0;
    for (int i = 0; i < n; i++)
      if (!ctree[i] && (!seen || slack[i] < delta)) begin
        delta = slack[i];
        seen = 1'b1;
      end
    for (int i = 0; i < n; i++) begin
      if (rtree[i]) rlab[i] -= delta;
      if (ctree[i]) clab[i] += delta;
      else slack[i] -= delta;
    end
  endfunction

  // max-weight perfect matching on the working costs
  function automatic void solve_matching(int n);
    int     root, wr, rd, fx, fy, x, nexty, matched;
    longint m;
    bit     found;
    for (int r = 0; r < n; r++) begin
      m = 0;
      rmate[r] = NO_MATE;
      cmate[r] = NO_MATE;
      clab[r] = 0;
      for (int c = 0; c < n; c++)
        if (mat[r*n+c] > m) m = mat[r*n+c];
      rlab[r] = m;
    end
    matched = 0;
    while (matched < n) begin
      root = 0; wr = 0; rd = 0; fx = 0; fy = 0;
      found = 1'b0;
      for (int i = 0; i < ahm_pkg::MAX_SIZE; i++) begin
        rtree[i] = 1'b0;
        ctree[i] = 1'b0;
        parent[i] = NO_MATE;
      end
      for (int r = 0; r < n; r++)
        if (rmate[r] == NO_MATE) begin
          root = r;
          break;
        end
      bfs_q[wr++] = root;
      parent[root] = ROOT_MARK;
      rtree[root] = 1'b1;
      for (int y = 0; y < n; y++) begin
        slack[y] = rlab[root] + clab[y] - mat[root*n+y];
        slack_row[y] = root;
      end
      while (1) begin
        while (rd < wr && !found) begin
          x = bfs_q[rd++];
          for (int y = 0; y < n; y++) begin
            if (ctree[y] || mat[x*n+y] != rlab[x] + clab[y]) continue;
            if (cmate[y] == NO_MATE) begin
              found = 1'b1; fx = x; fy = y;
              break;
            end
            ctree[y] = 1'b1;
            if (wr < ahm_pkg::MAX_SIZE) bfs_q[wr++] = cmate[y];
            grow_tree(n, cmate[y], x);
          end
        end
        if (found) break;
        shift_labels(n);
        wr = 0; rd = 0;
        for (int y = 0; y < n; y++) begin
          if (ctree[y] || slack[y] != 0) continue;
          if (cmate[y] == NO_MATE) begin
            found = 1'b1; fx = slack_row[y]; fy = y;
            break;
          end
          ctree[y] = 1'b1;
          if (!rtree[cmate[y]]) begin
            if (wr < ahm_pkg::MAX_SIZE) bfs_q[wr++] = cmate[y];
            grow_tree(n, cmate[y], slack_row[y]);
          end
        end
        if (found) break;
      end
      matched++;
      // flip the augmenting path back to the root
      for (int steps = 0; fx >= 0 && fx < n && fy >= 0 && fy < n && steps <= n; steps++) begin
        nexty = rmate[fx];
        cmate[fy] = fx;
        rmate[fx] = fy;
        fx = parent[fx];
        fy = nexty;
      end
    end
  endfunction

  // store one entry; on the last entry solve and queue the row matches
  function automatic void take_cost(logic signed [ahm_pkg::COST_W-1:0] v);
    int         n, c;
    longint     total, w;
    row_match_t rm;
    n = eff_size();
    total = 0;
    if (fill_count >= n*n) fill_count = 0;
    mat[fill_count] = minimize_reg ? -longint'(v) : longint'(v);
    fill_count++;
    if (fill_count < n*n) return;
    fill_count = 0;
    solve_matching(n);
    for (int r = 0; r < n; r++) begin
      c = rmate[r] & (ahm_pkg::MAX_SIZE-1);
      if (rmate[r] < 0 || rmate[r] >= n) c = 0;
      w = mat[r*n+c];
      total += w;
      rm.row = r[ahm_pkg::IDX_W-1:0];
      rm.col = c[ahm_pkg::IDX_W-1:0];
      rm.cost = minimize_reg ? ahm_pkg::COST_W'(-w) : ahm_pkg::COST_W'(w);
      rm.total = '0;
      rm.last = 1'b0;
      if (r == n-1) begin
        if (total < 0) total = -total;
        rm.total = ahm_pkg::TOTAL_W'(total);
        rm.last = 1'b1;
      end
      match_q.push_back(rm);
    end
  endfunction

  // driver: feeds cost items from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_cost(in_cost_value);
      if (!in_valid || in_ready) begin
        if (cost_feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_cost_value <= cost_feed_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and row match checks
  always @(posedge clk) begin
    row_match_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected item row %0d col %0d", $time, out_row_index,
                   out_matched_column);
          fail_count++;
        end else begin
          want = match_q.pop_front();
          if (out_row_index !== want.row || out_matched_column !== want.col ||
              out_row_cost !== want.cost || out_total_weight !== want.total ||
              out_last_result !== want.last) begin
            $display("%0t: mismatch exp row %0d col %0d cost %0d total %0d last %0b",
                     $time, want.row, want.col, want.cost, want.total, want.last);
            $display("%0t:          act row %0d col %0d cost %0d total %0d last %0b",
                     $time, out_row_index, out_matched_column, out_row_cost,
                     out_total_weight, out_last_result);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [ahm_pkg::CFG_IDX_W-1:0] idx,
                           logic [ahm_pkg::CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == ahm_pkg::CFG_SIZE) size_reg = data;
    else if (idx == ahm_pkg::CFG_MINIMIZE) minimize_reg = data[0];
    fill_count = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for every queued item and every row match, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (cost_feed_q.size() > 0 || in_valid || match_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [ahm_pkg::COST_W-1:0] pick_cost(int style);
    case (style)
      0: return ahm_pkg::COST_W'($urandom);
      1: return ahm_pkg::COST_W'($urandom_range(6) - 3);
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic run_matrix(logic [4:0] sz, bit mn, int style);
    int n;
    write_reg(ahm_pkg::CFG_SIZE, sz);
    write_reg(ahm_pkg::CFG_MINIMIZE, ahm_pkg::CFG_DW'(mn));
    n = eff_size();
    for (int i = 0; i < n*n; i++) cost_feed_q.push_back(pick_cost(style));
    drain();
  endtask

  task automatic random_matrices(int budget);
    int sz;
    while (budget > 0) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 5);
      run_matrix(sz[4:0], $urandom_range(1), $urandom_range(2));
      budget -= sz * sz;
    end
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cost_value = '0;
    out_ready = 1'b0;
    fail_count = 0;
    stall_cycles = 0;
    fill_count = 0;
    size_reg = 5'd16;
    minimize_reg = 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 86;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single entry extremes, size zero acting as one
    write_reg(ahm_pkg::CFG_SIZE, 5'd1);
    write_reg(ahm_pkg::CFG_MINIMIZE, 5'd1);
    cost_feed_q.push_back(16'sh8000);
    cost_feed_q.push_back(16'sh7fff);
    drain();
    write_reg(ahm_pkg::CFG_SIZE, 5'd0);
    cost_feed_q.push_back(16'sh0000);
    drain();
    // two by two extremes in maximize mode
    write_reg(ahm_pkg::CFG_SIZE, 5'd2);
    write_reg(ahm_pkg::CFG_MINIMIZE, 5'd0);
    cost_feed_q.push_back(16'sh7fff);
    cost_feed_q.push_back(16'sh8000);
    cost_feed_q.push_back(16'sh8000);
    cost_feed_q.push_back(16'sh7fff);
    drain();
    // all ties
    write_reg(ahm_pkg::CFG_SIZE, 5'd3);
    for (int i = 0; i < 9; i++) cost_feed_q.push_back(16'sd5);
    drain();
    // partial load aborted by a write to an unused index
    write_reg(ahm_pkg::CFG_SIZE, 5'd2);
    write_reg(ahm_pkg::CFG_MINIMIZE, 5'd1);
    for (int i = 0; i < 3; i++) cost_feed_q.push_back(pick_cost(0));
    drain();
    write_reg(CFG_UNUSED, 5'd3);
    for (int i = 0; i < 4; i++) cost_feed_q.push_back(pick_cost(0));
    drain();
    random_matrices(RAND_BUDGET);

    send_idle_pct = 86;
    recv_idle_pct = 28;
    random_matrices(RAND_BUDGET);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_matrices(RAND_BUDGET);

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
